>>> sv/great_circle_distance_macros.svh
// assertion macros for the great-circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gcd check failed");
`define GCD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gcd check failed");
`else
`define GCD_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define GCD_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> sv/gcd_pkg.sv
// types and constants of the great-circle distance block
`default_nettype none
package gcd_pkg;
  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  localparam int DIST_W = 23;
  localparam int DEG_W = 25;
  localparam int XY_W = 33;
  localparam int Z_W = 34;
  localparam int A_W = 31;
  localparam int REM_W = 61;
  localparam int ROOT_W = 31;
  localparam int SQRT_STEPS = 31;

  localparam logic signed [LAT_W-1:0] LAT_LIM = 24'sd5898240;
  localparam logic signed [LAT_W-1:0] LAT_NEG = -24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_LIM = 25'sd11796480;
  localparam logic signed [LON_W-1:0] LON_NEG = -25'sd11796480;
  localparam logic signed [LON_W:0] DEG90_Q17 = 26'sd11796480;
  localparam logic signed [LON_W:0] DEG90_NEG = -26'sd11796480;
  localparam logic signed [LON_W:0] DEG180_Q17 = 26'sd23592960;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] RECIP_45 = 32'd3054198966;
  localparam logic [A_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [A_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic [13:0] DIAMETER_KM = 14'd12742;
  localparam logic [DIST_W-1:0] DIST_MAX = 23'd5123873;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
    32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
    32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128,
    32'd64, 32'd32, 32'd16, 32'd8,
    32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;
endpackage
`default_nettype wire

>>> sv/gcd_if.sv
// valid/ready channel interfaces for coordinates in and distance out
`default_nettype none
interface gcd_in_if;
  import gcd_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_W-1:0] lat_first;
  logic signed [LON_W-1:0] lon_first;
  logic signed [LAT_W-1:0] lat_second;
  logic signed [LON_W-1:0] lon_second;
  modport source (output valid, lat_first, lon_first, lat_second, lon_second,
                  input ready);
  modport sink (input valid, lat_first, lon_first, lat_second, lon_second,
                output ready);
endinterface

interface gcd_out_if;
  import gcd_pkg::*;
  logic valid;
  logic ready;
  logic [DIST_W-1:0] distance_km;
  modport source (output valid, distance_km, input ready);
  modport sink (input valid, distance_km, output ready);
endinterface
`default_nettype wire

>>> sv/gcd_rad_cell.sv
// degrees q17 to radians q30, three registered steps
`default_nettype none
module gcd_rad_cell import gcd_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [DEG_W-1:0] deg_i,
  output logic signed [Z_W-1:0]  rad_o
);
  logic        neg_a_r, neg_b_r;
  logic [55:0] prod_a_r, prod_a_nxt;
  logic [36:0] quo_b_r;
  logic [31:0] q1_b_r, q1_b_nxt;
  logic [62:0] prod_b;
  logic [23:0] mag;
  logic [37:0] rem_c;
  logic [1:0]  fix_c;
  logic [31:0] q_c;
  logic signed [Z_W-1:0] rad_r, rad_nxt;

  assign mag = deg_i[DEG_W-1] ? 24'(-deg_i) : deg_i[23:0];
  assign prod_a_nxt = mag * PI_Q30;
  // quotient by 45 through a reciprocal, always low by at most three
  assign prod_b = prod_a_r[55:25] * RECIP_45;
  assign q1_b_nxt = prod_b[62:31];
  assign rem_c = {1'b0, quo_b_r} - ({6'd0, q1_b_r} * 38'd45);
  assign fix_c = 2'(rem_c >= 38'd45) + 2'(rem_c >= 38'd90) + 2'(rem_c >= 38'd135);
  assign q_c = q1_b_r + {30'd0, fix_c};
  assign rad_nxt = neg_b_r ? -$signed({2'b00, q_c}) : $signed({2'b00, q_c});

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= deg_i[DEG_W-1];
      prod_a_r <= prod_a_nxt;
      neg_b_r  <= neg_a_r;
      quo_b_r  <= prod_a_r[55:19];
      q1_b_r   <= q1_b_nxt;
      rad_r    <= rad_nxt;
    end
  end

  assign rad_o = rad_r;
endmodule
`default_nettype wire

>>> sv/gcd_cordic_cell.sv
// one cordic micro-rotation, rotation or vectoring mode
`default_nettype none
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic        clk,
  input  logic        en,
  input  cordic_vec_t v_i,
  output cordic_vec_t v_o
);
  localparam logic signed [Z_W-1:0] ATAN_Z = $signed({2'b00, ATAN_Q30[STAGE]});

  logic signed [XY_W-1:0] dx, dy;
  logic sub;
  cordic_vec_t v_r, v_nxt;

  assign dx = v_i.y >>> STAGE;
  assign dy = v_i.x >>> STAGE;
  assign sub = VECTOR ? (v_i.y < 0) : (v_i.z >= 0);

  always_comb begin
    if (sub) begin
      v_nxt.x = v_i.x - dx;
      v_nxt.y = v_i.y + dy;
      v_nxt.z = v_i.z - ATAN_Z;
    end else begin
      v_nxt.x = v_i.x + dx;
      v_nxt.y = v_i.y - dy;
      v_nxt.z = v_i.z + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_r <= v_nxt;
  end

  assign v_o = v_r;
endmodule
`default_nettype wire

>>> sv/gcd_sqrt_cell.sv
// one result bit of a digit-by-digit square root
`default_nettype none
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int K = 0
) (
  input  logic     clk,
  input  logic     en,
  input  sqrt_st_t s_i,
  output sqrt_st_t s_o
);
  logic [62:0] trial, rem_x, diff;
  sqrt_st_t s_r, s_nxt;

  assign trial = ({32'd0, s_i.root} << (K + 1)) + (63'd1 << (2 * K));
  assign rem_x = {2'b00, s_i.rem};
  assign diff  = rem_x - trial;

  always_comb begin
    if (rem_x >= trial) begin
      s_nxt.rem  = diff[REM_W-1:0];
      s_nxt.root = s_i.root | (31'd1 << K);
    end else begin
      s_nxt = s_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end

  assign s_o = s_r;
endmodule
`default_nettype wire

>>> sv/great_circle_distance.sv
// haversine great-circle distance, fully pipelined chain of cells
//
//  channel   dir  payload                                        beat when
//  in_beat   in   lat_first lon_first lat_second lon_second      valid && ready
//  out_beat  out  distance_km (km, 8 fraction bits)              valid && ready
//
// one beat accepted per cycle while the pipe is not held; the stages in order:
// (input clamp, difference, 3 radian steps, rotation cordic cells, 3 product
// steps, 31 square-root cells, vectoring cordic cells, angle clamp, scale)
// the whole pipe advances together; it holds only while the output register
// is full and not taken, so ready = output empty or taken this cycle
// synchronous active-low reset clears the valid bits only, no clearing pass
`default_nettype none
`include "great_circle_distance_macros.svh"
module great_circle_distance import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  gcd_in_if.sink     in_beat,
  gcd_out_if.source  out_beat
);
  localparam int N = CORDIC_STAGES;
  localparam int L = 2 * N + 41;
  localparam int RAD_IDX = 4;
  localparam int A_IDX = N + 7;
  localparam int CZ_IDX = L - 2;
  localparam logic signed [32:0] ONE_S = 33'sd1073741824;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = $signed({3'b000, HALF_PI_Q30});

  // pipe valid bits, last one is the output register
  logic [L-1:0] vld_r;
  logic en;

  assign en = !vld_r[L-1] || out_beat.ready;
  assign in_beat.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_beat.valid};
    end
  end

  // clamp coordinates into range
  logic signed [LAT_W-1:0] lat1_r, lat2_r, lat1_nxt, lat2_nxt;
  logic signed [LON_W-1:0] lon1_r, lon2_r, lon1_nxt, lon2_nxt;

  always_comb begin
    lat1_nxt = in_beat.lat_first;
    if (in_beat.lat_first > LAT_LIM) lat1_nxt = LAT_LIM;
    else if (in_beat.lat_first < LAT_NEG) lat1_nxt = LAT_NEG;
    lat2_nxt = in_beat.lat_second;
    if (in_beat.lat_second > LAT_LIM) lat2_nxt = LAT_LIM;
    else if (in_beat.lat_second < LAT_NEG) lat2_nxt = LAT_NEG;
    lon1_nxt = in_beat.lon_first;
    if (in_beat.lon_first > LON_LIM) lon1_nxt = LON_LIM;
    else if (in_beat.lon_first < LON_NEG) lon1_nxt = LON_NEG;
    lon2_nxt = in_beat.lon_second;
    if (in_beat.lon_second > LON_LIM) lon2_nxt = LON_LIM;
    else if (in_beat.lon_second < LON_NEG) lon2_nxt = LON_NEG;
  end

  // half-angles in degrees q17: a q16 difference is already the half angle
  logic signed [DEG_W-1:0] deg_r [4];
  logic signed [DEG_W-1:0] hlat;
  logic signed [LON_W:0] hlon, hlon_w;

  assign hlat = $signed({lat2_r[LAT_W-1], lat2_r}) - $signed({lat1_r[LAT_W-1], lat1_r});
  assign hlon = $signed({lon2_r[LON_W-1], lon2_r}) - $signed({lon1_r[LON_W-1], lon1_r});

  // sin squared repeats every 180 degrees, fold the longitude half-angle
  always_comb begin
    hlon_w = hlon;
    if (hlon > DEG90_Q17) hlon_w = hlon - DEG180_Q17;
    else if (hlon < DEG90_NEG) hlon_w = hlon + DEG180_Q17;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= lat1_nxt;
      lat2_r <= lat2_nxt;
      lon1_r <= lon1_nxt;
      lon2_r <= lon2_nxt;
      deg_r[0] <= hlat;
      deg_r[1] <= hlon_w[DEG_W-1:0];
      deg_r[2] <= {lat1_r, 1'b0};
      deg_r[3] <= {lat2_r, 1'b0};
    end
  end

  // four angles: half dlat, half dlon, lat1, lat2
  logic signed [Z_W-1:0] rad [4];
  cordic_vec_t rot [4][N+1];

  for (genvar g = 0; g < 4; g++) begin : g_angle
    gcd_rad_cell u_rad (.clk(clk), .en(en), .deg_i(deg_r[g]), .rad_o(rad[g]));
    assign rot[g][0] = '{x: GAIN_Q30, y: '0, z: rad[g]};
    for (genvar s = 0; s < N; s++) begin : g_rot
      gcd_cordic_cell #(.STAGE(s), .VECTOR(1'b0)) u_cell (
        .clk(clk), .en(en), .v_i(rot[g][s]), .v_o(rot[g][s+1]));
    end
  end

  // haversine term a = sin^2(hlat) + cos lat1 cos lat2 sin^2(hlon)
  logic signed [63:0] p_sl, p_c12, p_so, p_t;
  logic signed [31:0] sl2_r, c12_r, so2_r, sl2_d_r, t_r;
  logic signed [32:0] a_sum;
  logic [A_W-1:0] a_r, a_nxt;

  assign p_sl  = $signed(rot[0][N].y[31:0]) * $signed(rot[0][N].y[31:0]);
  assign p_so  = $signed(rot[1][N].y[31:0]) * $signed(rot[1][N].y[31:0]);
  assign p_c12 = $signed(rot[2][N].x[31:0]) * $signed(rot[3][N].x[31:0]);
  assign p_t   = c12_r * so2_r;
  assign a_sum = $signed({sl2_d_r[31], sl2_d_r}) + $signed({t_r[31], t_r});

  always_comb begin
    if (a_sum < 0) a_nxt = '0;
    else if (a_sum > ONE_S) a_nxt = ONE_Q30;
    else a_nxt = a_sum[A_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl2_r   <= p_sl[61:30];
      c12_r   <= p_c12[61:30];
      so2_r   <= p_so[61:30];
      sl2_d_r <= sl2_r;
      t_r     <= p_t[61:30];
      a_r     <= a_nxt;
    end
  end

  // square roots of a and 1-a, one result bit per cell
  sqrt_st_t sqa [SQRT_STEPS+1];
  sqrt_st_t sqb [SQRT_STEPS+1];
  logic [A_W-1:0] one_minus_a;

  assign one_minus_a = ONE_Q30 - a_r;
  assign sqa[0] = '{rem: {a_r, 30'd0}, root: '0};
  assign sqb[0] = '{rem: {one_minus_a, 30'd0}, root: '0};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    gcd_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_sa (
      .clk(clk), .en(en), .s_i(sqa[j]), .s_o(sqa[j+1]));
    gcd_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_sb (
      .clk(clk), .en(en), .s_i(sqb[j]), .s_o(sqb[j+1]));
  end

  // half central angle from atan2(sqrt a, sqrt(1-a))
  cordic_vec_t vec [N+1];

  assign vec[0] = '{x: $signed({2'b00, sqb[SQRT_STEPS].root}),
                    y: $signed({2'b00, sqa[SQRT_STEPS].root}), z: '0};

  for (genvar s = 0; s < N; s++) begin : g_vec
    gcd_cordic_cell #(.STAGE(s), .VECTOR(1'b1)) u_cell (
      .clk(clk), .en(en), .v_i(vec[s]), .v_o(vec[s+1]));
  end

  // clamp to [0, pi/2] and scale by the diameter with rounding
  logic [A_W-1:0] cz_r, cz_nxt;
  logic [45:0] dprod;
  logic [23:0] d_full;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  always_comb begin
    if (vec[N].z < 0) cz_nxt = '0;
    else if (vec[N].z > HALF_PI_Z) cz_nxt = HALF_PI_Q30;
    else cz_nxt = vec[N].z[A_W-1:0];
  end

  assign dprod = cz_r * DIAMETER_KM + 46'd2097152;
  assign d_full = dprod[45:22];
  assign dist_nxt = (d_full > {1'b0, DIST_MAX}) ? DIST_MAX : d_full[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      cz_r   <= cz_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_beat.valid = vld_r[L-1];
  assign out_beat.distance_km = dist_r;

  `GCD_ASSERT_NOW(a_in_range, clk, rst_n, vld_r[A_IDX], a_r <= ONE_Q30)
  `GCD_ASSERT_NOW(rad_folded, clk, rst_n, vld_r[RAD_IDX],
    rad[1] <= HALF_PI_Z && rad[1] >= -HALF_PI_Z)
  `GCD_ASSERT_NOW(cz_in_range, clk, rst_n, vld_r[CZ_IDX], cz_r <= HALF_PI_Q30)
  `GCD_ASSERT_NOW(dist_capped, clk, rst_n, vld_r[L-1], dist_r <= DIST_MAX)
  `GCD_ASSERT_NEXT(pipe_frozen, clk, rst_n, !en, vld_r == $past(vld_r))
endmodule
`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for the haversine great-circle distance block
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import gcd_pkg::*;

  localparam int STAGES = 24;
  // pipe depth, the stage count of the block; the drain below adds some margin
  localparam int PIPE_DEPTH = 2 * STAGES + 41;
  localparam int RANDOM_BEATS = 1350;
  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;

  logic clk;
  logic rst_n;

  gcd_in_if in_chan ();
  gcd_out_if out_chan ();

  great_circle_distance #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_chan.sink),
    .out_beat (out_chan.source)
  );

  // ---------------------------------------------------------------------
  // fixed-point distance predictor
  // ---------------------------------------------------------------------

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // degrees q17 to radians q30, quotient truncated toward zero
  function automatic longint q17_to_rad(longint deg);
    return (deg * longint'(PI_Q30)) / (2 * LON_MAX);
  endfunction

  // rotation mode: returns sine and cosine of z (q30)
  function automatic void rotate(longint z, output longint sin_v, output longint cos_v);
    longint x, y, dx, dy;
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    sin_v = y;
    cos_v = x;
  endfunction

  // vectoring mode: angle of (x, y) in q30
  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] haversine_km(
    logic signed [LAT_W-1:0] la1, logic signed [LON_W-1:0] lo1,
    logic signed [LAT_W-1:0] la2, logic signed [LON_W-1:0] lo2);
    longint lat1, lon1, lat2, lon2, dlat, dlon;
    longint s_lat, s_lon, c1, c2, junk, hav, ang;
    longint unsigned r_a, r_b, km_q8;
    lat1 = clip(longint'(la1), -LAT_MAX, LAT_MAX);
    lon1 = clip(longint'(lo1), -LON_MAX, LON_MAX);
    lat2 = clip(longint'(la2), -LAT_MAX, LAT_MAX);
    lon2 = clip(longint'(lo2), -LON_MAX, LON_MAX);
    // q16 differences read as q17 half-angles
    dlat = lat2 - lat1;
    dlon = lon2 - lon1;
    // sin squared has period pi, fold the half longitude difference
    if (dlon > LON_MAX) dlon -= 2 * LON_MAX;
    else if (dlon < -LON_MAX) dlon += 2 * LON_MAX;
    rotate(q17_to_rad(dlat), s_lat, junk);
    rotate(q17_to_rad(dlon), s_lon, junk);
    rotate(q17_to_rad(lat1 * 2), junk, c1);
    rotate(q17_to_rad(lat2 * 2), junk, c2);
    hav = ((s_lat * s_lat) >>> 30) + ((((c1 * c2) >>> 30) * ((s_lon * s_lon) >>> 30)) >>> 30);
    hav = clip(hav, 0, longint'(ONE_Q30));
    r_a = int_root(longint'(unsigned'(hav)) << 30);
    r_b = int_root((longint'(ONE_Q30) - hav) << 30);
    ang = clip(vector_angle(longint'(r_b), longint'(r_a)), 0, longint'(HALF_PI_Q30));
    km_q8 = (longint'(ang) * longint'(DIAMETER_KM) + (64'd1 << 21)) >> 22;
    if (km_q8 > longint'(DIST_MAX)) km_q8 = longint'(DIST_MAX);
    return km_q8[DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard: queue of predicted distances, oldest first
  // ---------------------------------------------------------------------
  class distance_board;
    logic [DIST_W-1:0] pending_km[$];
    int mismatches = 0;
    int checked = 0;

    function void note_point_pair(logic signed [LAT_W-1:0] la1,
                                  logic signed [LON_W-1:0] lo1,
                                  logic signed [LAT_W-1:0] la2,
                                  logic signed [LON_W-1:0] lo2);
      pending_km.insert(pending_km.size(), haversine_km(la1, lo1, la2, lo2));
    endfunction

    function void check_distance(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      checked++;
      if (pending_km.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat: %0d", got);
        return;
      end
      want = pending_km.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance_km mismatch at beat %0d: expected %0d actual %0d",
                   checked, want, got);
      end
    endfunction
  endclass

  distance_board board;
  int src_idle_pct;
  int snk_idle_pct;
  int sent_beats;

  // ---------------------------------------------------------------------
  // clock, reset, receiver stalls
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver: ready decided per cycle at the rising edge
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // output monitor: ready and valid are stable mid-cycle, the beat lands at the next edge
  always @(negedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) board.check_distance(out_chan.distance_km);
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------
  task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.lat_first <= la1[LAT_W-1:0];
    in_chan.lon_first <= lo1[LON_W-1:0];
    in_chan.lat_second <= la2[LAT_W-1:0];
    in_chan.lon_second <= lo2[LON_W-1:0];
    // accepted at a rising edge with ready high
    forever begin
      @(negedge clk);
      if (in_chan.ready) break;
    end
    @(posedge clk);
    board.note_point_pair(la1[LAT_W-1:0], lo1[LON_W-1:0], la2[LAT_W-1:0], lo2[LON_W-1:0]);
    sent_beats++;
  endtask

  function automatic longint any_lat();
    return longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic longint any_lon();
    return longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
  endfunction

  // full field, out-of-range values included
  function automatic longint raw_field(int width);
    logic [31:0] r;
    r = $urandom();
    return longint'(signed'(r << (32 - width))) >>> (32 - width);
  endfunction

  // one random pair; most in range, some nearby points, some near antipodal, some raw field noise
  task automatic send_random_pair();
    int pick;
    longint la1, lo1;
    pick = $urandom_range(99);
    la1 = any_lat();
    lo1 = any_lon();
    if (pick < 60) begin
      send_pair(la1, lo1, any_lat(), any_lon());
    end else if (pick < 80) begin
      // nearby points, small differences
      send_pair(la1, lo1,
                clip(la1 + longint'($urandom_range(4000)) - 2000, -LAT_MAX, LAT_MAX),
                clip(lo1 + longint'($urandom_range(4000)) - 2000, -LON_MAX, LON_MAX));
    end else if (pick < 90) begin
      // near antipodal
      send_pair(la1, lo1, -la1 + longint'($urandom_range(200)) - 100,
                lo1 >= 0 ? lo1 - LON_MAX + longint'($urandom_range(200)) - 100
                         : lo1 + LON_MAX + longint'($urandom_range(200)) - 100);
    end else begin
      send_pair(raw_field(LAT_W), raw_field(LON_W), raw_field(LAT_W), raw_field(LON_W));
    end
  endtask

  initial begin
    longint lat_top, lon_top;
    board = new();
    sent_beats = 0;
    src_idle_pct = 13;
    snk_idle_pct = 58;
    lat_top = (64'd1 << (LAT_W - 1)) - 1;
    lon_top = (64'd1 << (LON_W - 1)) - 1;
    in_chan.valid = 1'b0;
    in_chan.lat_first = '0;
    in_chan.lon_first = '0;
    in_chan.lat_second = '0;
    in_chan.lon_second = '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed: identical points, poles, antipodes, field extremes
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(0, 0, 0, LON_MAX / 2);
    // longitude difference beyond 180 degrees either way, folded
    send_pair(0, -LON_MAX + 65536, 0, LON_MAX - 65536);
    send_pair(0, LON_MAX - 65536, 0, -LON_MAX + 65536);
    send_pair(1000, 0, -1000, 1);
    // out-of-range coordinates clamp
    send_pair(lat_top, lon_top, -lat_top - 1, -lon_top - 1);
    send_pair(-lat_top - 1, -lon_top - 1, lat_top, lon_top);
    send_pair(lat_top, 0, LAT_MAX, 0);
    send_pair(LAT_MAX + 1, LON_MAX + 1, -LAT_MAX - 1, -LON_MAX - 1);
    send_pair(-1, -1, 1, 1);
    send_pair(LAT_MAX - 1, 12345, -LAT_MAX + 1, 12345 - LON_MAX);
    send_pair(3276800, 1966080, -2228224, -8060928);
    send_pair(1, 0, 0, 0);
    send_pair(0, 1, 0, 0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) begin
        src_idle_pct = 58;
        snk_idle_pct = 13;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_random_pair();
    end
    in_chan.valid <= 1'b0;

    // drain, then give the pipe a little longer for stray beats
    while (board.pending_km.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    $display("sent %0d coordinate pairs (directed extremes, clamps, folds, random mix)",
             sent_beats);
    $display("checked %0d distance beats, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_km.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
